[src/pwmdiv_pkg.sv]
// Shared constants for the PWM divider and wrap search block.
`timescale 1ns / 1ps

package pwmdiv_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CLK_W  = 28;
    localparam int unsigned WRAP_W = 16;

    localparam logic [WRAP_W-1:0] TOP_LIMIT = 16'd65534;

    localparam logic [DATA_W-1:0] RECIP_FIVE  = 32'hCCCC_CCCD;
    localparam logic [DATA_W-1:0] RECIP_THREE = 32'hAAAA_AAAB;

    localparam logic [DATA_W-1:0] MIN_D_FIVE  = 32'd80;
    localparam logic [DATA_W-1:0] MIN_D_THREE = 32'd48;
    localparam logic [DATA_W-1:0] MIN_D_TWO   = 32'd32;
    localparam logic [DATA_W-1:0] DIV_MIN     = 32'd16;
    localparam logic [DATA_W-1:0] DIV_MAX     = 32'd4096;

    localparam logic [CLK_W-1:0] SYS_CLOCK_RESET = 28'd125000000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_HIGH = 2'd1,
        ST_LOW  = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

endpackage

[src/pwm_divider_top_search.sv]
// Top level: PWM clock divider and wrap search sequencer.
//
//  channel | valid     | flow control | payload
//  --------+-----------+--------------+--------------------------------
//  input   | in_valid  | in_stall     | target_freq
//  output  | out_valid | out_stall    | divider_q4, wrap_top, status
//  config  | cfg_valid | cfg_ready    | sys_clock_hz
//
// A request runs the 32-step division, then search rounds that each try a five
// and, where that fails, a three or a two; the closing round takes none of them.
// A zero frequency goes straight to the result.
// A finished request waits in the result register on out_stall while the next
// one is taken; the one after that holds in_stall high until it moves on.
// Reset sets sys_clock_hz to 125 MHz and empties the output register.
`timescale 1ns / 1ps

module pwm_divider_top_search
    import pwmdiv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] target_freq,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] divider_q4,
    output logic [WRAP_W-1:0] wrap_top,
    output logic [1:0]        status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CLK_W-1:0]  sys_clock_hz
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL5,
        S_TEST5,
        S_MUL3,
        S_TEST3,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CLK_W-1:0]  clk_hz_reg, clk_hz_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [WRAP_W-1:0] wrap_reg, wrap_next;
    status_t           st_reg, st_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_div_reg, out_div_next;
    logic [WRAP_W-1:0] out_wrap_reg, out_wrap_next;
    status_t           out_st_reg, out_st_next;

    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic              mul_load;
    logic              mul_five;
    logic [DATA_W-1:0] mul_quo;
    logic              mul_exact;

    logic [WRAP_W+2:0] wrap_x5;
    logic [WRAP_W+1:0] wrap_x3;
    logic [WRAP_W:0]   wrap_x2;

    assign wrap_x5 = {1'b0, wrap_reg, 2'b00} + {3'b000, wrap_reg};
    assign wrap_x3 = {1'b0, wrap_reg, 1'b0} + {2'b00, wrap_reg};
    assign wrap_x2 = {wrap_reg, 1'b0};

    pwmdiv_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({clk_hz_reg, 4'b0000}),
        .divisor  (target_freq),
        .done     (div_done),
        .quotient (div_quo)
    );

    pwmdiv_recip u_recip (
        .clk      (clk),
        .load     (mul_load),
        .sel_five (mul_five),
        .operand  (d_reg),
        .quotient (mul_quo),
        .exact    (mul_exact)
    );

    assign in_stall  = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign mul_load  = (state_reg == S_MUL5) || (state_reg == S_MUL3);
    assign mul_five  = state_reg == S_MUL5;
    assign div_start = (state_reg == S_IDLE) && in_valid && (target_freq != '0);

    always_comb
    begin
        state_next     = state_reg;
        clk_hz_next    = clk_hz_reg;
        d_next         = d_reg;
        wrap_next      = wrap_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_div_next   = out_div_reg;
        out_wrap_next  = out_wrap_reg;
        out_st_next    = out_st_reg;

        if (cfg_valid)
        begin
            clk_hz_next = sys_clock_hz;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (target_freq == '0)
                    begin
                        d_next     = '0;
                        wrap_next  = WRAP_W'(1);
                        st_next    = ST_ZERO;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    d_next     = div_quo;
                    wrap_next  = WRAP_W'(1);
                    state_next = S_MUL5;
                end
            end
            S_MUL5:
            begin
                state_next = S_TEST5;
            end
            S_TEST5:
            begin
                if (d_reg >= MIN_D_FIVE && mul_exact
                    && wrap_x5 <= {3'b000, TOP_LIMIT})
                begin
                    d_next     = mul_quo;
                    wrap_next  = wrap_x5[WRAP_W-1:0];
                    state_next = S_MUL5;
                end
                else
                begin
                    state_next = S_MUL3;
                end
            end
            S_MUL3:
            begin
                state_next = S_TEST3;
            end
            S_TEST3:
            begin
                if (d_reg >= MIN_D_THREE && mul_exact
                    && wrap_x3 <= {2'b00, TOP_LIMIT})
                begin
                    d_next     = mul_quo;
                    wrap_next  = wrap_x3[WRAP_W-1:0];
                    state_next = S_MUL5;
                end
                else if (d_reg >= MIN_D_TWO && wrap_x2 <= {1'b0, TOP_LIMIT})
                begin
                    d_next     = {1'b0, d_reg[DATA_W-1:1]};
                    wrap_next  = wrap_x2[WRAP_W-1:0];
                    state_next = S_MUL5;
                end
                else
                begin
                    priority if (d_reg < DIV_MIN)
                    begin
                        d_next    = '0;
                        wrap_next = WRAP_W'(1);
                        st_next   = ST_HIGH;
                    end
                    else if (d_reg >= DIV_MAX)
                    begin
                        d_next    = '0;
                        wrap_next = WRAP_W'(1);
                        st_next   = ST_LOW;
                    end
                    else
                    begin
                        st_next = ST_OK;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_div_next   = d_reg;
                    out_wrap_next  = wrap_reg;
                    out_st_next    = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clk_hz_reg    <= SYS_CLOCK_RESET;
            d_reg         <= '0;
            wrap_reg      <= WRAP_W'(1);
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
            out_div_reg   <= '0;
            out_wrap_reg  <= WRAP_W'(1);
            out_st_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            clk_hz_reg    <= clk_hz_next;
            d_reg         <= d_next;
            wrap_reg      <= wrap_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            out_div_reg   <= out_div_next;
            out_wrap_reg  <= out_wrap_next;
            out_st_reg    <= out_st_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign divider_q4 = out_div_reg;
    assign wrap_top   = out_wrap_reg;
    assign status     = out_st_reg;

endmodule

[src/pwmdiv_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pwmdiv_divider
    import pwmdiv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    logic [DATA_W-1:0]         rem_reg, rem_next;
    logic [DATA_W-1:0]         quo_reg, quo_next;
    logic [DATA_W-1:0]         dsr_reg, dsr_next;
    logic [$clog2(DATA_W)-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [DATA_W:0]           trial;
    logic [DATA_W:0]           diff;
    logic                      ge;

    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/pwmdiv_recip.sv]
// Shared reciprocal multiplier: divides by five or three and flags exactness.
`timescale 1ns / 1ps

module pwmdiv_recip
    import pwmdiv_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic              sel_five,
    input  logic [DATA_W-1:0] operand,
    output logic [DATA_W-1:0] quotient,
    output logic              exact
);

    logic [2*DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0]   op_reg;
    logic                five_reg;
    logic [DATA_W+1:0]   back;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= operand * (sel_five ? RECIP_FIVE : RECIP_THREE);
            op_reg   <= operand;
            five_reg <= sel_five;
        end
    end

    // q = floor(x * ceil(2^34/5) / 2^34) or floor(x * ceil(2^33/3) / 2^33)
    assign quotient = five_reg ? {2'b00, prod_reg[2*DATA_W-1:DATA_W+2]}
                               : {1'b0, prod_reg[2*DATA_W-1:DATA_W+1]};

    assign back = five_reg ? ({quotient, 2'b00} + {2'b00, quotient})
                           : ({1'b0, quotient, 1'b0} + {2'b00, quotient});

    assign exact = back == {2'b00, op_reg};

endmodule

[verif/pwm_divider_top_search_tb.sv]
// Testbench for the PWM divider block: random and directed requests against a predictor.
`timescale 1ns / 1ps

module pwm_divider_top_search_tb;
    import pwmdiv_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned PHASE_COUNT   = 6;
    localparam int unsigned PHASE_ITEMS   = 265;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned REPORT_MAX    = 10;

    typedef struct packed {
        logic [DATA_W-1:0] divider;
        logic [WRAP_W-1:0] wrap;
        status_t           st;
    } pwm_setting_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [DATA_W-1:0] target_freq  = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [DATA_W-1:0] divider_q4;
    logic [WRAP_W-1:0] wrap_top;
    logic [1:0]        status;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [CLK_W-1:0]  sys_clock_hz = '0;

    logic [DATA_W-1:0] pending_freqs[$];
    pwm_setting_t      expected_settings[$];
    logic [CLK_W-1:0]  model_sys_clock = SYS_CLOCK_RESET;
    int unsigned       send_idle_pct   = 0;
    int unsigned       recv_idle_pct   = 0;
    logic              hold_off        = 1'b0;
    int unsigned       accepted_count  = 0;
    int unsigned       fail_count      = 0;
    int unsigned       cycle_count     = 0;

    pwm_divider_top_search u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .target_freq  (target_freq),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .divider_q4   (divider_q4),
        .wrap_top     (wrap_top),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .sys_clock_hz (sys_clock_hz)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Greedy factor search: fives, then threes, then twos into the wrap
    function automatic pwm_setting_t predict_setting(input logic [DATA_W-1:0] freq,
                                                     input logic [CLK_W-1:0] clk_hz);
        pwm_setting_t r;
        logic [63:0]  d;
        logic [31:0]  wrap;
        bit           searching;
        r.divider = '0;
        r.wrap    = 16'd1;
        r.st      = ST_ZERO;
        if (freq == '0)
            return r;
        d         = ({36'd0, clk_hz} * 64'd16) / {32'd0, freq};
        wrap      = 32'd1;
        searching = 1'b1;
        while (searching)
        begin
            if (d >= MIN_D_FIVE && d % 5 == 0 && wrap * 5 <= TOP_LIMIT)
            begin
                d    = d / 5;
                wrap = wrap * 5;
            end
            else if (d >= MIN_D_THREE && d % 3 == 0 && wrap * 3 <= TOP_LIMIT)
            begin
                d    = d / 3;
                wrap = wrap * 3;
            end
            else if (d >= MIN_D_TWO && wrap * 2 <= TOP_LIMIT)
            begin
                d    = d / 2;
                wrap = wrap * 2;
            end
            else
                searching = 1'b0;
        end
        if (d < DIV_MIN)
            r.st = ST_HIGH;
        else if (d >= DIV_MAX)
            r.st = ST_LOW;
        else
        begin
            r.divider = d[DATA_W-1:0];
            r.wrap    = wrap[WRAP_W-1:0];
            r.st      = ST_OK;
        end
        return r;
    endfunction

    // Random and edge frequencies, and frequencies that land on real dividers with products of 2, 3 and 5 folded in
    function automatic logic [DATA_W-1:0] pick_target_freq(input logic [CLK_W-1:0] clk_hz);
        logic [63:0]       num;
        logic [63:0]       den;
        logic [63:0]       quo;
        logic [DATA_W-1:0] f;
        int unsigned       kind;
        int unsigned       rounds;
        num  = {36'd0, clk_hz} * 64'd16;
        kind = $urandom_range(0, 9);
        f    = '0;
        case (kind)
            0, 1:
                f = $urandom;
            2:
                case ($urandom_range(0, 4))
                    0: f = '0;
                    1: f = 32'd1;
                    2: f = {4'd0, clk_hz};
                    3: f = {4'd0, clk_hz} + 32'd1;
                    default: f = '1;
                endcase
            3, 4, 5:
                f = $urandom >> $urandom_range(0, 31);
            default:
            begin
                den    = 64'($urandom_range(16, 4095));
                rounds = $urandom_range(0, 16);
                repeat (rounds)
                begin
                    case ($urandom_range(0, 2))
                        0: den = den * 2;
                        1: den = den * 3;
                        default: den = den * 5;
                    endcase
                end
                quo = num / den;
                f   = quo[DATA_W-1:0];
                if ($urandom_range(0, 3) == 0)
                    f = f + 32'd1;
                if (f == '0)
                    f = 32'd1;
            end
        endcase
        return f;
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, what);
    endfunction

    // Driver: offers queued requests, holds payload while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_settings.push_back(predict_setting(target_freq, model_sys_clock));
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_freqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    target_freq <= pending_freqs.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: takes results, compares with the oldest expectation
    always @(posedge clk)
    begin
        pwm_setting_t got;
        pwm_setting_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {divider_q4, wrap_top, status};
                if (expected_settings.size() == 0)
                    note_failure($sformatf("unexpected result div=%0d wrap=%0d status=%0d",
                                           divider_q4, wrap_top, status));
                else
                begin
                    want = expected_settings.pop_front();
                    if (got !== want)
                        note_failure($sformatf(
                            {"mismatch: exp div=%0d wrap=%0d status=%0d, ",
                             "got div=%0d wrap=%0d status=%0d"},
                            want.divider, want.wrap, want.st, got.divider, got.wrap, got.st));
                end
            end
            out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pwm_divider_top_search test failed");
            $finish;
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (accepted_count >= 100);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic write_sys_clock(input logic [CLK_W-1:0] hz);
        @(posedge clk);
        cfg_valid    <= 1'b1;
        sys_clock_hz <= hz;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid       <= 1'b0;
        model_sys_clock  = hz;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (pending_freqs.size() != 0 || in_valid || expected_settings.size() != 0);
    endtask

    initial
    begin
        logic [CLK_W-1:0]  phase_clocks[PHASE_COUNT];
        logic [DATA_W-1:0] directed_freqs[$];
        phase_clocks   = '{28'd125000000, 28'd268435455, 28'd1, 28'd48000000, 28'd0,
                           CLK_W'($urandom_range(1, 268435455))};
        // Boundaries at 125 MHz: divider exactly 16 and 15, one factor of each kind, extremes
        directed_freqs = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
                           32'd125000000, 32'd125000001, 32'd62500000, 32'd41666666,
                           32'd25000000, 32'd7812500, 32'd1953125, 32'd20000, 32'd25000,
                           32'd1000, 32'd488, 32'd50, 32'd30, 32'd15, 32'd8};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_sys_clock(phase_clocks[p]);
            @(posedge clk);
            if (p < 2)
            begin
                send_idle_pct <= 9;
                recv_idle_pct <= 68;
            end
            else if (p < 4)
            begin
                send_idle_pct <= 68;
                recv_idle_pct <= 9;
            end
            else
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            if (p == 0)
                foreach (directed_freqs[i])
                    pending_freqs.push_back(directed_freqs[i]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_freqs.push_back(pick_target_freq(phase_clocks[p]));
            wait_drained();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("pwm_divider_top_search test passed");
        else
            $display("pwm_divider_top_search test failed");
        $finish;
    end

endmodule
